// ----- design/srf_pkg.sv -----
// Package: state and event codes plus the item, result and context types of the endpoint.
`timescale 1ns / 1ps

package srf_pkg;

   // Endpoint states
   localparam logic [2:0] ST_PREP     = 3'd0;
   localparam logic [2:0] ST_REGREQ   = 3'd1;
   localparam logic [2:0] ST_IDLE     = 3'd2;
   localparam logic [2:0] ST_CALL     = 3'd3;
   localparam logic [2:0] ST_DEREGREQ = 3'd4;
   localparam logic [2:0] ST_RELEASED = 3'd5;
   localparam logic [2:0] ST_FREED    = 3'd6;

   // Event codes
   localparam logic [3:0] FN_REG_ACCEPT   = 4'd0;
   localparam logic [3:0] FN_REG_DENY     = 4'd1;
   localparam logic [3:0] FN_DEREG_ACCEPT = 4'd2;
   localparam logic [3:0] FN_DEREG_DENY   = 4'd3;
   localparam logic [3:0] FN_SETUP        = 4'd4;
   localparam logic [3:0] FN_DESTROY      = 4'd5;
   localparam logic [3:0] FN_CONSTRUCT    = 4'd6;
   localparam logic [3:0] FN_REG_REQ      = 4'd7;
   localparam logic [3:0] FN_DEREG_REQ    = 4'd8;
   localparam logic [3:0] FN_QUEUE_EMPTY  = 4'd9;
   localparam logic [3:0] FN_QUERY        = 4'd10;

   localparam int RSP_BITS = 51;
   localparam int RSP_PAD  = 5;

   typedef struct packed {
      logic [3:0]  func;
      logic        attributes_present;
      logic [23:0] call_reference;
      logic [2:0]  target_state;
   } srf_item_type;

   typedef struct packed {
      logic        query_granted;
      logic [2:0]  current_state;
      logic        id_valid;
      logic [15:0] assigned_id;
      logic        freed;
      logic        deregister_issued;
      logic [23:0] offered_call_reference;
      logic        call_offered;
      logic        fatal_missing_service;
      logic        wrong_state;
      logic        approved;
   } srf_result_type;

   typedef struct packed {
      logic [2:0] fsm_state;
      logic       marked_for_deletion;
      logic       first_construction;
   } srf_ctx_type;

endpackage

// ----- design/srf_event_decode.sv -----
// Event decoder: next endpoint context and result for one event item.
`timescale 1ns / 1ps

module srf_event_decode
   import srf_pkg::*;
(
   input  srf_ctx_type    ctx,
   input  srf_item_type   item,
   input  logic [15:0]    service_id,
   output srf_ctx_type    ctx_next,
   output srf_result_type result
);

   always_comb begin
      ctx_next = ctx;
      result   = '0;
      if (ctx.fsm_state == ST_FREED) begin
         result.wrong_state = 1'b1;
      end else if (!item.attributes_present && item.func != FN_CONSTRUCT &&
                   item.func != FN_QUEUE_EMPTY && item.func != FN_QUERY) begin
         result.fatal_missing_service = 1'b1;
      end else begin
         unique case (item.func)
            FN_REG_ACCEPT: begin
               if (ctx.fsm_state == ST_REGREQ) begin
                  ctx_next.fsm_state = ST_IDLE;
                  result.approved    = 1'b1;
               end else result.wrong_state = 1'b1;
            end
            FN_REG_DENY: begin
               if (ctx.fsm_state == ST_REGREQ) begin
                  ctx_next.fsm_state = ST_RELEASED;
                  result.approved    = 1'b1;
               end else result.wrong_state = 1'b1;
            end
            FN_DEREG_ACCEPT: begin
               if (ctx.fsm_state == ST_DEREGREQ) begin
                  if (ctx.marked_for_deletion) begin
                     ctx_next.fsm_state = ST_FREED;
                     result.freed       = 1'b1;
                  end else begin
                     ctx_next.fsm_state = ST_RELEASED;
                     result.approved    = 1'b1;
                  end
               end else result.wrong_state = 1'b1;
            end
            FN_DEREG_DENY: begin
               if (ctx.fsm_state == ST_DEREGREQ) result.approved = 1'b1;
               else result.wrong_state = 1'b1;
            end
            FN_SETUP: begin
               if (ctx.fsm_state == ST_IDLE || ctx.fsm_state == ST_CALL) begin
                  ctx_next.fsm_state            = ST_CALL;
                  result.call_offered           = 1'b1;
                  result.offered_call_reference = item.call_reference;
                  result.approved               = 1'b1;
               end else result.wrong_state = 1'b1;
            end
            FN_DESTROY: begin
               result.assigned_id           = service_id;
               result.id_valid              = 1'b1;
               result.approved              = 1'b1;
               ctx_next.marked_for_deletion = 1'b1;
               if (ctx.fsm_state inside {ST_IDLE, ST_CALL, ST_REGREQ, ST_DEREGREQ}) begin
                  result.deregister_issued = (ctx.fsm_state != ST_DEREGREQ);
                  ctx_next.fsm_state       = ST_RELEASED;
               end else begin
                  ctx_next.fsm_state = ST_FREED;
                  result.freed       = 1'b1;
               end
            end
            FN_CONSTRUCT: begin
               if (ctx.first_construction) begin
                  result.assigned_id          = service_id;
                  result.id_valid             = 1'b1;
                  ctx_next.first_construction = 1'b0;
               end
            end
            FN_REG_REQ: begin
               if (ctx.fsm_state == ST_PREP) begin
                  ctx_next.fsm_state = ST_REGREQ;
                  result.approved    = 1'b1;
               end else result.wrong_state = 1'b1;
            end
            FN_DEREG_REQ: begin
               if (ctx.fsm_state == ST_IDLE || ctx.fsm_state == ST_CALL) begin
                  ctx_next.fsm_state = ST_DEREGREQ;
                  result.approved    = 1'b1;
               end else result.wrong_state = 1'b1;
            end
            FN_QUEUE_EMPTY: begin
               if (ctx.fsm_state == ST_CALL) ctx_next.fsm_state = ST_IDLE;
            end
            FN_QUERY: begin
               unique case (item.target_state)
                  ST_REGREQ:   result.query_granted = (ctx.fsm_state == ST_PREP);
                  ST_IDLE:     result.query_granted = (ctx.fsm_state == ST_REGREQ);
                  ST_DEREGREQ: result.query_granted = (ctx.fsm_state == ST_IDLE) ||
                                                      (ctx.fsm_state == ST_CALL);
                  default:     result.query_granted = 1'b0;
               endcase
            end
            default: begin
               // unknown event: context unchanged, no flags raised
            end
         endcase
      end
      result.current_state = ctx_next.fsm_state;
   end

endmodule

// ----- design/service_registration_fsm.sv -----
// Top level: service-registration endpoint with event input stage and result register.
`timescale 1ns / 1ps
// An accepted item passes the input stage, then the result register, to rsp_*.
// Throughput: one item per cycle while rsp_tready stays high; the input stage and
//   the result register each hold one item, so one more item is taken while a
//   result waits, then req_tready drops until rsp_tready returns.
// Reset: synchronous, active high; state goes to preparing, deletion mark clears,
//   first-construction flag sets, service_id returns to 0, both stages empty.

module service_registration_fsm
   import srf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // event item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [0] attributes_present, [24:1] call_reference,
                                    // [27:25] target_state, [31:28] zero
   input  logic [3:0]  req_tuser,   // [3:0] func
   // result item out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] approved, [1] wrong_state,
                                    // [2] fatal_missing_service, [3] call_offered,
                                    // [27:4] offered_call_reference,
                                    // [28] deregister_issued, [29] freed,
                                    // [45:30] assigned_id, [46] id_valid,
                                    // [49:47] current_state, [50] query_granted,
                                    // [55:51] zero
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic           in_valid_ff;
   srf_item_type   in_item_ff;
   logic           rsp_valid_ff;
   srf_result_type rsp_data_ff;
   srf_ctx_type    ctx_ff;
   srf_ctx_type    ctx_in;
   srf_result_type result_in;
   logic [15:0]    service_id_ff;
   logic           advance;
   logic           req_accept;

   // Move the staged item into the result register when that slot frees up.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Input stage: capture event payload
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.func               <= req_tuser;
         in_item_ff.attributes_present <= req_tdata[0];
         in_item_ff.call_reference     <= req_tdata[24:1];
         in_item_ff.target_state       <= req_tdata[27:25];
      end
   end

   // Service identifier register
   always_ff @(posedge clock) begin
      if (reset) begin
         service_id_ff <= '0;
      end else if (csr_wr_en) begin
         service_id_ff <= csr_wr_data;
      end
   end

   srf_event_decode u_decode (
      .ctx        (ctx_ff),
      .item       (in_item_ff),
      .service_id (service_id_ff),
      .ctx_next   (ctx_in),
      .result     (result_in)
   );

   // Endpoint context: advance once per item as it leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.fsm_state           <= ST_PREP;
         ctx_ff.marked_for_deletion <= 1'b0;
         ctx_ff.first_construction  <= 1'b1;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_data_ff};

   // Freed is terminal until reset.
   a_freed_sticky: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.fsm_state == ST_FREED |=> ctx_ff.fsm_state == ST_FREED)
      else $error("left freed state");

   // The first-construction flag never comes back without reset.
   a_first_once: assert property (@(posedge clock) disable iff (reset)
      !ctx_ff.first_construction |=> !ctx_ff.first_construction)
      else $error("first-construction flag set again");

   // A reported free always shows the freed state.
   a_freed_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.freed |-> rsp_data_ff.current_state == ST_FREED)
      else $error("freed result without freed state");

   // An offered call always leaves the endpoint in active call.
   a_call_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.call_offered |-> rsp_data_ff.current_state == ST_CALL)
      else $error("call offered outside active call");

   // The context only moves when an item leaves the input stage.
   a_ctx_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ctx_ff))
      else $error("context changed with no item");

endmodule

// ----- tb/service_registration_fsm_tb.sv -----
// Testbench for the service-registration endpoint: lifetime walk with an event-level predictor.
`timescale 1ns / 1ps

module service_registration_fsm_tb;
   import srf_pkg::*;

   // Tracks the endpoint's state, deletion mark, first-construction flag and
   // service id, and holds the outcome each accepted event should produce.
   class registration_tracker;
      logic [2:0]     fsm;
      bit             marked;
      bit             first_build;
      logic [15:0]    service_id;
      srf_result_type outcomes[$];
      int             errors;

      function new();
         fsm         = ST_PREP;
         marked      = 1'b0;
         first_build = 1'b1;
         service_id  = '0;
         errors      = 0;
      endfunction

      function int pending();
         return outcomes.size();
      endfunction

      // Advance the predicted endpoint by one event and queue its outcome.
      function void log_event(srf_item_type it);
         srf_result_type r;
         logic           ok;
         logic           bad;
         r   = '0;
         ok  = 1'b0;
         bad = 1'b0;
         if (fsm == ST_FREED) begin
            bad = 1'b1;
         end else if (!it.attributes_present && it.func != FN_CONSTRUCT &&
                      it.func != FN_QUEUE_EMPTY && it.func != FN_QUERY) begin
            r.fatal_missing_service = 1'b1;
         end else begin
            case (it.func)
               FN_REG_ACCEPT: begin
                  if (fsm == ST_REGREQ) begin
                     fsm = ST_IDLE;
                     ok  = 1'b1;
                  end else bad = 1'b1;
               end
               FN_REG_DENY: begin
                  if (fsm == ST_REGREQ) begin
                     fsm = ST_RELEASED;
                     ok  = 1'b1;
                  end else bad = 1'b1;
               end
               FN_DEREG_ACCEPT: begin
                  if (fsm == ST_DEREGREQ) begin
                     if (marked) begin
                        fsm     = ST_FREED;
                        r.freed = 1'b1;
                     end else begin
                        fsm = ST_RELEASED;
                        ok  = 1'b1;
                     end
                  end else bad = 1'b1;
               end
               FN_DEREG_DENY: begin
                  if (fsm == ST_DEREGREQ) ok = 1'b1;
                  else bad = 1'b1;
               end
               FN_SETUP: begin
                  if (fsm == ST_IDLE || fsm == ST_CALL) begin
                     fsm                      = ST_CALL;
                     r.call_offered           = 1'b1;
                     r.offered_call_reference = it.call_reference;
                     ok                       = 1'b1;
                  end else bad = 1'b1;
               end
               FN_DESTROY: begin
                  r.assigned_id = service_id;
                  r.id_valid    = 1'b1;
                  marked        = 1'b1;
                  ok            = 1'b1;
                  if (fsm == ST_PREP || fsm == ST_RELEASED) begin
                     fsm     = ST_FREED;
                     r.freed = 1'b1;
                  end else begin
                     r.deregister_issued = (fsm != ST_DEREGREQ);
                     fsm                 = ST_RELEASED;
                  end
               end
               FN_CONSTRUCT: begin
                  if (first_build) begin
                     r.assigned_id = service_id;
                     r.id_valid    = 1'b1;
                     first_build   = 1'b0;
                  end
               end
               FN_REG_REQ: begin
                  if (fsm == ST_PREP) begin
                     fsm = ST_REGREQ;
                     ok  = 1'b1;
                  end else bad = 1'b1;
               end
               FN_DEREG_REQ: begin
                  if (fsm == ST_IDLE || fsm == ST_CALL) begin
                     fsm = ST_DEREGREQ;
                     ok  = 1'b1;
                  end else bad = 1'b1;
               end
               FN_QUEUE_EMPTY: begin
                  if (fsm == ST_CALL) fsm = ST_IDLE;
               end
               FN_QUERY: begin
                  case (it.target_state)
                     ST_REGREQ:   r.query_granted = (fsm == ST_PREP);
                     ST_IDLE:     r.query_granted = (fsm == ST_REGREQ);
                     ST_DEREGREQ: r.query_granted = (fsm == ST_IDLE || fsm == ST_CALL);
                     default:     r.query_granted = 1'b0;
                  endcase
               end
               default: ;
            endcase
         end
         r.approved      = ok;
         r.wrong_state   = bad;
         r.current_state = fsm;
         outcomes.push_back(r);
      endfunction

      function void check_field(string name, logic [23:0] want, logic [23:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one result item against the oldest queued outcome.
      function void compare_result(srf_result_type got);
         srf_result_type want;
         if (outcomes.size() == 0) begin
            $error("result item with no outcome pending");
            errors++;
            return;
         end
         want = outcomes.pop_front();
         check_field("approved", 24'(want.approved), 24'(got.approved));
         check_field("wrong_state", 24'(want.wrong_state), 24'(got.wrong_state));
         check_field("fatal_missing_service", 24'(want.fatal_missing_service),
                     24'(got.fatal_missing_service));
         check_field("call_offered", 24'(want.call_offered), 24'(got.call_offered));
         check_field("offered_call_reference", want.offered_call_reference,
                     got.offered_call_reference);
         check_field("deregister_issued", 24'(want.deregister_issued),
                     24'(got.deregister_issued));
         check_field("freed", 24'(want.freed), 24'(got.freed));
         check_field("assigned_id", 24'(want.assigned_id), 24'(got.assigned_id));
         check_field("id_valid", 24'(want.id_valid), 24'(got.id_valid));
         check_field("current_state", 24'(want.current_state), 24'(got.current_state));
         check_field("query_granted", 24'(want.query_granted), 24'(got.query_granted));
      endfunction
   endclass

   localparam int QUIET_LIMIT = 2000;   // cycles with no item moving on either side
   localparam int SQUEEZE_CYCLES = 150; // long receiver hold-off to back up the input

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   registration_tracker tracker = new();
   int  quiet_cycles = 0;
   bit  offering = 1'b0;  // req_tvalid is (or is about to be) high
   bit  squeeze = 1'b0;   // ask the receiver for one long hold-off

   service_registration_fsm dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Check every result item taken, and count cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.compare_result(srf_result_type'(rsp_tdata[RSP_BITS-1:0]));
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Stop the run if the handshakes stay quiet for too long.
   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Pace rsp_tready: mostly ready, short stalls, now and then a long one,
   // and one very long hold-off when the stimulus asks for it.
   initial begin : rsp_pacing
      int pick;
      int span;
      @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_tready <= 1'b0;
            for (int i = 0; i < SQUEEZE_CYCLES; i++) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(1, 12);
            end else if (pick < 75) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(30, 80);
            end else if (pick < 94) begin
               rsp_tready <= 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               span = $urandom_range(20, 60);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   function automatic srf_item_type make_event(logic [3:0] func, logic attr,
                                               logic [23:0] cref, logic [2:0] tgt);
      srf_item_type it;
      it.func               = func;
      it.attributes_present = attr;
      it.call_reference     = cref;
      it.target_state       = tgt;
      return it;
   endfunction

   // Random event that keeps the endpoint in its state (idle and call may swap):
   // events that would move it on are redrawn unless the object is absent (then fatal).
   function automatic srf_item_type pick_event();
      srf_item_type it;
      logic         moves_on;
      int           r;
      it.attributes_present = ($urandom_range(0, 9) != 0);
      it.call_reference     = 24'($urandom);
      it.target_state       = 3'($urandom);
      do begin
         r       = $urandom_range(0, 99);
         it.func = (r < 8) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
         case (tracker.fsm)
            ST_PREP:     moves_on = (it.func == FN_REG_REQ || it.func == FN_DESTROY);
            ST_REGREQ:   moves_on = (it.func == FN_REG_ACCEPT || it.func == FN_REG_DENY ||
                                     it.func == FN_DESTROY);
            ST_IDLE,
            ST_CALL:     moves_on = (it.func == FN_DEREG_REQ || it.func == FN_DESTROY);
            ST_DEREGREQ: moves_on = (it.func == FN_DEREG_ACCEPT || it.func == FN_DESTROY);
            ST_RELEASED: moves_on = (it.func == FN_DESTROY);
            default:     moves_on = 1'b0;
         endcase
      end while (it.attributes_present && moves_on);
      return it;
   endfunction

   // Offer one item and hold it until the block takes it; log it on acceptance.
   task automatic send_event(input srf_item_type it);
      req_tvalid <= 1'b1;
      offering = 1'b1;
      req_tdata  <= {4'b0, it.target_state, it.call_reference, it.attributes_present};
      req_tuser  <= it.func;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.log_event(it);
   endtask

   // Drop req_tvalid for a number of cycles; zero keeps the stream going.
   task automatic req_pause(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Send one item, then maybe idle: mostly none, often short, a few long gaps.
   task automatic offer(input srf_item_type it, input bit allow_gap);
      int pick;
      send_event(it);
      pick = $urandom_range(0, 99);
      if (allow_gap) begin
         if (pick >= 92)      req_pause($urandom_range(10, 40));
         else if (pick >= 60) req_pause($urandom_range(1, 3));
      end
   endtask

   task automatic run_segment(input int count, input int back_to_back);
      for (int i = 0; i < count; i++) offer(pick_event(), i >= back_to_back);
   endtask

   // Hold off the input until every outcome is back and the pipeline is empty.
   task automatic settle();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_service_id(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.service_id = value;
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_service_id(16'hFFFF);

      // Preparing: construction twice, absent object, unknown codes, queries,
      // and every event that preparing rejects.
      offer(make_event(FN_CONSTRUCT, 1'b0, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_CONSTRUCT, 1'b1, 24'hFFFFFF, 3'd7), 1'b1);
      offer(make_event(4'd15, 1'b1, 24'hFFFFFF, 3'd7), 1'b1);
      offer(make_event(4'd11, 1'b0, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_REG_ACCEPT, 1'b0, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_QUEUE_EMPTY, 1'b0, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_QUERY, 1'b0, 24'h0, ST_REGREQ), 1'b1);
      offer(make_event(FN_QUERY, 1'b1, 24'h0, ST_PREP), 1'b1);
      offer(make_event(FN_QUERY, 1'b1, 24'h0, ST_IDLE), 1'b1);
      offer(make_event(FN_QUERY, 1'b1, 24'h0, ST_DEREGREQ), 1'b1);
      offer(make_event(FN_REG_ACCEPT, 1'b1, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_REG_DENY, 1'b1, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_DEREG_ACCEPT, 1'b1, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_DEREG_DENY, 1'b1, 24'h0, 3'd0), 1'b1);
      offer(make_event(FN_SETUP, 1'b1, 24'hFFFFFF, 3'd0), 1'b1);
      offer(make_event(FN_DEREG_REQ, 1'b1, 24'h0, 3'd0), 1'b1);
      run_segment(150, 0);

      // Register requested.
      offer(make_event(FN_REG_REQ, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);
      offer(make_event(FN_QUERY, 1'b1, 24'h0, ST_IDLE), 1'b1);
      run_segment(150, 0);
      offer(make_event(FN_REG_ACCEPT, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);

      // Active: calls come and go; the receiver holds off once at the start
      // while items keep coming, so the input backs up.
      settle();
      write_service_id(16'h0000);
      offer(make_event(FN_SETUP, 1'b1, 24'hFFFFFF, 3'd0), 1'b1);
      offer(make_event(FN_SETUP, 1'b1, 24'h000000, 3'd7), 1'b1);
      offer(make_event(FN_QUEUE_EMPTY, 1'b1, 24'h0, 3'd0), 1'b1);
      squeeze = 1'b1;
      run_segment(875, 40);

      // Leave active either through deregistration or by destroy; the seed picks.
      settle();
      write_service_id(16'($urandom));
      if ($urandom_range(0, 1) == 1) begin
         offer(make_event(FN_DEREG_REQ, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);
         run_segment(250, 0);
         offer(make_event(FN_DEREG_ACCEPT, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);
      end else begin
         offer(make_event(FN_DESTROY, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);
         run_segment(250, 0);
      end
      run_segment(200, 0);

      // Released, then destroy frees the endpoint for good.
      settle();
      write_service_id(16'($urandom));
      offer(make_event(FN_DESTROY, 1'b1, 24'($urandom), 3'($urandom)), 1'b1);
      run_segment(200, 0);
      settle();

      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/srf_pkg.sv
design/srf_event_decode.sv
design/service_registration_fsm.sv
tb/service_registration_fsm_tb.sv
